/* sv/legendre_poly_eval_core_defines.svh */
// assertion macros for the legendre evaluator core
// expects aclk and aresetn in the scope of use
`ifndef LEGENDRE_POLY_EVAL_CORE_DEFINES_SVH
`define LEGENDRE_POLY_EVAL_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LPE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lpe_pkg.sv */
// shared constants and rounding helper for the legendre evaluator
// no dependencies
package lpe_pkg;

    localparam int MW = 34;           // shared multiplier operand width
    localparam int PW = 2 * MW;       // product width
    localparam int DIV_DW = 110;      // divider dividend shift register
    localparam int DIV_RW = 61;       // remainder and divisor width
    localparam logic [6:0] DIV_BITS_REC = 7'd50;
    localparam logic [6:0] DIV_BITS_DER = 7'd110;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic [47:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SAT_NEG = 48'h8000_0000_0000;
    localparam logic [60:0] ONE_Q60 = 61'h1000_0000_0000_0000;

    // product in q60 to q30, to nearest, ties away from zero
    function automatic logic signed [37:0] round_q30(input logic signed [PW-1:0] v);
        logic [PW-1:0] mag;
        logic [PW-1:0] sum;
        logic [37:0]   m;
        mag = v[PW-1] ? (~v + PW'(1)) : v;
        sum = mag + (PW'(1) << 29);
        m   = sum[67:30];
        return v[PW-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

/* sv/legendre_poly_eval_core.sv */
// legendre polynomial evaluator: value, first and second derivative
// uses lpe_pkg and legendre_poly_eval_core_defines.svh
//
// usage
//   s_ channel: one beat carries the point x (signed q1.30) in s_tdata[31:0].
//   m_ channel: one beat carries P_n(x), P_n'(x) and P_n''(x), 30 fraction bits.
//   cfg_we/cfg_wdata write the degree n; only write it while the core is idle.
// timing
//   one point at a time; s_tready is high only while the core is idle.
//   n of 0 or 1: the result is set straight from x, with no recurrence.
//   n >= 2: each recurrence step runs the shared multiplier through S_RT,
//   S_RK1, S_RK2, S_RK3 and S_RSUB, then a 50-bit quotient on the radix-2
//   divider (one quotient bit per cycle); the recurrence runs once, or twice
//   when x sits at +1 or -1. The two derivative quotients take 110 quotient
//   bits each, plus multiplier steps and set-up.
// reset and stalls
//   aresetn (synchronous, active low) clears the degree to 0 and empties the core.
//   a result held by a stalled m_tready stays in the output register; the core
//   then takes the next point and parks its result until the output frees up.
`include "legendre_poly_eval_core_defines.svh"

module legendre_poly_eval_core #(
    parameter int MAX_DEGREE = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [5:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,      // [31:0] point
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata       // [31:0] value, [79:32] first_derivative,
                                       // [127:80] second_derivative
);
    import lpe_pkg::*;

    localparam int NW = $clog2(MAX_DEGREE + 2);

    typedef enum logic [4:0] {
        S_IDLE, S_RT, S_RK1, S_RK2, S_RK3, S_RSUB, S_RDIV,
        S_DA, S_DA2, S_DDEN, S_DM, S_DDIV1, S_DHI, S_DLO, S_DNN, S_DC,
        S_DNUM, S_DDIV2, S_OUT
    } state_t;

    state_t state_reg;

    logic [5:0]           degree_reg;
    logic signed [31:0]   x_reg, xd_reg, cx_reg;
    logic [30:0]          ax_reg;
    logic [NW-1:0]        n_reg, i_reg;
    logic                 pass_reg;
    logic signed [31:0]   a_reg, b_reg, qn_reg, qm_reg, t_reg;
    logic signed [47:0]   acc_reg;
    logic signed [32:0]   a1_reg;
    logic [60:0]          den_reg;
    logic [54:0]          hi_reg;
    logic signed [51:0]   bsig_reg;
    logic signed [31:0]   val_reg;
    logic signed [47:0]   d1_reg, d2_reg;
    logic [127:0]         m_tdata_reg;
    logic                 m_tvalid_reg;

    // shared multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod_reg;

    // shared radix-2 divider
    logic [DIV_DW-1:0]    div_d_reg;
    logic [DIV_RW-1:0]    div_r_reg, div_den_reg;
    logic [47:0]          div_q_reg, div_cap_reg;
    logic                 div_sat_reg, div_neg_reg;
    logic [6:0]           div_cnt_reg;

    logic                 div_run;
    logic [DIV_RW:0]      div_rr;
    logic                 div_ge;
    logic [DIV_RW-1:0]    div_r_next;
    logic [48:0]          div_qsh;
    logic                 div_over;
    logic [47:0]          div_q_next;

    // combinational helpers
    logic signed [31:0]   pt_clamp, pt_nudge;
    logic [NW-1:0]        n_eff;
    logic signed [47:0]   rnum;
    logic [47:0]          rmag;
    logic [31:0]          rq_clamp;
    logic signed [31:0]   rp;
    logic signed [32:0]   a1_w;
    logic [32:0]          a1_mag;
    logic [47:0]          pmag;
    logic [55:0]          bm;
    logic signed [52:0]   dnum;
    logic [52:0]          dmag;
    logic [47:0]          res_d1, res_d2;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign div_run  = (state_reg == S_RDIV) || (state_reg == S_DDIV1)
                   || (state_reg == S_DDIV2);

    always_comb begin
        if ($signed(s_tdata) > ONE_Q30) begin
            pt_clamp = ONE_Q30;
        end else if ($signed(s_tdata) < -ONE_Q30) begin
            pt_clamp = -ONE_Q30;
        end else begin
            pt_clamp = $signed(s_tdata);
        end
        if (pt_clamp == ONE_Q30) begin
            pt_nudge = ONE_Q30 - 32'sd2;
        end else if (pt_clamp == -ONE_Q30) begin
            pt_nudge = -ONE_Q30 + 32'sd2;
        end else begin
            pt_nudge = pt_clamp;
        end
        if (32'(degree_reg) > 32'(MAX_DEGREE)) begin
            n_eff = NW'(MAX_DEGREE);
        end else begin
            n_eff = NW'(degree_reg);
        end
    end

    // divider step
    always_comb begin
        div_rr     = {div_r_reg, div_d_reg[DIV_DW-1]};
        div_ge     = (div_rr >= {1'b0, div_den_reg});
        div_r_next = div_ge ? DIV_RW'(div_rr - {1'b0, div_den_reg}) : DIV_RW'(div_rr);
        div_qsh    = {div_q_reg, div_ge};
        div_over   = div_sat_reg || (div_qsh > {1'b0, div_cap_reg});
        div_q_next = div_over ? div_cap_reg : div_qsh[47:0];
    end

    always_comb begin
        rnum     = acc_reg - $signed(prod_reg[47:0]);
        rmag     = rnum[47] ? 48'(-rnum) : 48'(rnum);
        rq_clamp = (div_q_next > 48'(ONE_Q30)) ? ONE_Q30 : div_q_next[31:0];
        rp       = div_neg_reg ? -$signed(rq_clamp) : $signed(rq_clamp);
        a1_w     = 33'(round_q30(prod_reg)) - 33'(qm_reg);
        a1_mag   = a1_reg[32] ? 33'(-a1_reg) : 33'(a1_reg);
        pmag     = d1_reg[47] ? 48'(-d1_reg) : 48'(d1_reg);
        bm       = 56'(hi_reg >> 5)
                 + ((56'({hi_reg[4:0], 24'b0}) + 56'(prod_reg[54:0])) >> 29);
        dnum     = 53'(bsig_reg) - 53'(prod_reg);
        dmag     = dnum[52] ? 53'(-dnum) : 53'(dnum);
        res_d1   = div_neg_reg ? 48'(-div_q_next) : div_q_next;
        res_d2   = res_d1;
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RT: begin
                mul_a = MW'(cx_reg);
                mul_b = MW'(b_reg);
            end
            S_RK2: begin
                mul_a = MW'({i_reg, 1'b0}) - MW'(1);
                mul_b = MW'(t_reg);
            end
            S_RK3: begin
                mul_a = MW'(i_reg) - MW'(1);
                mul_b = MW'(a_reg);
            end
            S_DA: begin
                mul_a = MW'(xd_reg);
                mul_b = MW'(qn_reg);
            end
            S_DA2: begin
                mul_a = MW'(ax_reg);
                mul_b = MW'(ax_reg);
            end
            S_DDEN: begin
                mul_a = MW'(n_reg);
                mul_b = MW'(a1_mag);
            end
            S_DHI: begin
                mul_a = MW'(ax_reg);
                mul_b = MW'(pmag[47:24]);
            end
            S_DLO: begin
                mul_a = MW'(ax_reg);
                mul_b = MW'(pmag[23:0]);
            end
            S_DNN: begin
                mul_a = MW'(n_reg);
                mul_b = MW'(n_reg) + MW'(1);
            end
            S_DC: begin
                mul_a = prod_reg[MW-1:0];
                mul_b = MW'(qn_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            degree_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                degree_reg <= cfg_wdata;
            end
            if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (div_run) begin
                div_d_reg   <= {div_d_reg[DIV_DW-2:0], 1'b0};
                div_r_reg   <= div_r_next;
                div_q_reg   <= div_q_next;
                div_sat_reg <= div_over;
                div_cnt_reg <= div_cnt_reg - 7'd1;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x_reg    <= pt_clamp;
                        xd_reg   <= pt_nudge;
                        cx_reg   <= pt_nudge;
                        ax_reg   <= pt_nudge[31] ? 31'(-pt_nudge) : 31'(pt_nudge);
                        n_reg    <= n_eff;
                        i_reg    <= NW'(2);
                        pass_reg <= 1'b0;
                        a_reg    <= ONE_Q30;
                        b_reg    <= pt_nudge;
                        if (n_eff == NW'(0)) begin
                            val_reg   <= ONE_Q30;
                            d1_reg    <= '0;
                            d2_reg    <= '0;
                            state_reg <= S_OUT;
                        end else if (n_eff == NW'(1)) begin
                            val_reg   <= pt_clamp;
                            d1_reg    <= 48'(ONE_Q30);
                            d2_reg    <= '0;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_RT;
                        end
                    end
                end
                S_RT:  state_reg <= S_RK1;
                S_RK1: begin
                    t_reg     <= 32'(round_q30(prod_reg));
                    state_reg <= S_RK2;
                end
                S_RK2: state_reg <= S_RK3;
                S_RK3: begin
                    acc_reg   <= prod_reg[47:0];
                    state_reg <= S_RSUB;
                end
                S_RSUB: begin
                    div_d_reg   <= {50'(rmag) + 50'(i_reg >> 1), 60'b0};
                    div_r_reg   <= '0;
                    div_q_reg   <= '0;
                    div_sat_reg <= 1'b0;
                    div_neg_reg <= rnum[47];
                    div_den_reg <= DIV_RW'(i_reg);
                    div_cap_reg <= SAT_POS;
                    div_cnt_reg <= DIV_BITS_REC;
                    state_reg   <= S_RDIV;
                end
                S_RDIV: begin
                    if (div_cnt_reg == 7'd1) begin
                        if (i_reg != n_reg) begin
                            a_reg     <= b_reg;
                            b_reg     <= rp;
                            i_reg     <= i_reg + NW'(1);
                            state_reg <= S_RT;
                        end else if (!pass_reg && x_reg != xd_reg) begin
                            // end point: second pass with the exact x for the value
                            qn_reg    <= rp;
                            qm_reg    <= b_reg;
                            pass_reg  <= 1'b1;
                            cx_reg    <= x_reg;
                            a_reg     <= ONE_Q30;
                            b_reg     <= x_reg;
                            i_reg     <= NW'(2);
                            state_reg <= S_RT;
                        end else begin
                            if (!pass_reg) begin
                                qn_reg <= rp;
                                qm_reg <= b_reg;
                            end
                            val_reg   <= rp;
                            state_reg <= S_DA;
                        end
                    end
                end
                S_DA:  state_reg <= S_DA2;
                S_DA2: begin
                    a1_reg    <= a1_w;
                    state_reg <= S_DDEN;
                end
                S_DDEN: begin
                    den_reg   <= ONE_Q60 - prod_reg[60:0];
                    state_reg <= S_DM;
                end
                S_DM: begin
                    div_d_reg   <= {prod_reg[49:0], 60'b0};
                    div_r_reg   <= '0;
                    div_q_reg   <= '0;
                    div_sat_reg <= 1'b0;
                    div_neg_reg <= (a1_reg > 33'sd0);
                    div_den_reg <= den_reg;
                    div_cap_reg <= (a1_reg > 33'sd0) ? SAT_NEG : SAT_POS;
                    div_cnt_reg <= DIV_BITS_DER;
                    state_reg   <= S_DDIV1;
                end
                S_DDIV1: begin
                    if (div_cnt_reg == 7'd1) begin
                        d1_reg    <= res_d1;
                        state_reg <= S_DHI;
                    end
                end
                S_DHI: state_reg <= S_DLO;
                S_DLO: begin
                    hi_reg    <= prod_reg[54:0];
                    state_reg <= S_DNN;
                end
                S_DNN: begin
                    // sign of 2 x P' from the signs of x and P'
                    bsig_reg  <= (xd_reg[31] != d1_reg[47]) ? -$signed(52'(bm))
                                                           : $signed(52'(bm));
                    state_reg <= S_DC;
                end
                S_DC:  state_reg <= S_DNUM;
                S_DNUM: begin
                    div_d_reg   <= {dmag[49:0], 60'b0};
                    div_r_reg   <= '0;
                    div_q_reg   <= '0;
                    div_sat_reg <= 1'b0;
                    div_neg_reg <= dnum[52];
                    div_den_reg <= den_reg;
                    div_cap_reg <= dnum[52] ? SAT_NEG : SAT_POS;
                    div_cnt_reg <= DIV_BITS_DER;
                    state_reg   <= S_DDIV2;
                end
                S_DDIV2: begin
                    if (div_cnt_reg == 7'd1) begin
                        d2_reg    <= res_d2;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // park until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg <= {d2_reg, d1_reg, val_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `LPE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after a beat")
    `LPE_ASSERT_SAME(a_div_count_live, div_run, div_cnt_reg != 7'd0, "divider count zero")
    `LPE_ASSERT_SAME(a_step_in_range, state_reg == S_RT, i_reg >= NW'(2) && i_reg <= n_reg, "bad step")

endmodule

/* verif/tb_top.sv */
// testbench for legendre_poly_eval_core: value, first and second derivative of P_n(x)
// self-checking against an in-bench fixed-point predictor; depends on the core's rtl only
`timescale 1ns / 100ps

module tb_top;

    localparam logic signed [63:0] ONE = 64'sd1 << 30;
    localparam int                 DEG_CAP = 32;
    localparam logic [63:0]        CAP_POS = (64'd1 << 47) - 64'd1;
    localparam logic [63:0]        CAP_NEG = 64'd1 << 47;

    typedef struct packed {
        logic [47:0] second_der;
        logic [47:0] first_der;
        logic [31:0] value;
    } lp_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [5:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;      // [31:0] point
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;      // [31:0] value, [79:32] first_derivative,
                                // [127:80] second_derivative

    lp_result_t   poly_q[$];
    logic [5:0]   degree_reg;
    int           fail_cnt;
    int           tx_idle_pct;
    int           rx_stall_pct;
    int           hold_cycles;

    legendre_poly_eval_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // ---------------- predictor ----------------

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint with_sign(input bit neg, input logic [63:0] m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_q30(input longint v);
        return with_sign(v < 0, (mag(v) + (64'd1 << 29)) >> 30);
    endfunction

    // floor(m * 2^60 / den), clipped at cap
    function automatic logic [63:0] quot_sat(input logic [63:0] m, input logic [63:0] den,
                                             input logic [63:0] cap);
        logic [127:0] q;
        if (den == 0)
            return (m != 0) ? cap : 64'd0;
        q = ({64'd0, m} << 60) / {64'd0, den};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    task automatic legendre_recur(input int n, input longint x, output longint pn,
                                  output longint pm);
        longint a, b, t, num, p;
        logic [63:0] m;
        a = ONE;
        b = x;
        for (int i = 2; i <= n; i++) begin
            t = round_q30(x * b);
            num = longint'(2 * i - 1) * t - longint'(i - 1) * a;
            m = (mag(num) + 64'(i / 2)) / 64'(i);
            p = with_sign(num < 0, m);
            if (p > ONE) p = ONE;
            if (p < -ONE) p = -ONE;
            a = b;
            b = p;
        end
        pn = b;
        pm = a;
    endtask

    task automatic predict_poly(input logic [31:0] pt, output lp_result_t r);
        longint x, xd, val, d1, d2, pn, pm, qn, qm, a, b, c, num;
        logic [63:0] ax, den, pmag, hi, lo, bm;
        int n;
        x = longint'($signed(pt));
        if (x > ONE) x = ONE;
        if (x < -ONE) x = -ONE;
        n = (degree_reg > DEG_CAP) ? DEG_CAP : int'(degree_reg);
        d1 = 0;
        d2 = 0;
        if (n == 0) begin
            val = ONE;
        end else if (n == 1) begin
            val = x;
            d1 = ONE;
        end else begin
            legendre_recur(n, x, pn, pm);
            val = pn;
            xd = x;
            // ends are nudged inward for the derivatives only
            if (xd == ONE) xd = ONE - 2;
            if (xd == -ONE) xd = -ONE + 2;
            legendre_recur(n, xd, qn, qm);
            ax = mag(xd);
            den = (64'd1 << 60) - ax * ax;
            a = round_q30(xd * qn) - qm;
            d1 = with_sign(a > 0, quot_sat(64'(n) * mag(a), den, (a > 0) ? CAP_NEG : CAP_POS));
            pmag = mag(d1);
            hi = ax * (pmag >> 24);
            lo = ax * (pmag & 64'hFF_FFFF);
            bm = (hi >> 5) + ((((hi & 64'd31) << 24) + lo) >> 29);
            b = with_sign((xd < 0) != (d1 < 0), bm);
            c = longint'(n * (n + 1)) * qn;
            num = b - c;
            d2 = with_sign(num < 0, quot_sat(mag(num), den, (num < 0) ? CAP_NEG : CAP_POS));
        end
        r.value = val[31:0];
        r.first_der = d1[47:0];
        r.second_der = d2[47:0];
    endtask

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        lp_result_t exp_r;
        lp_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (poly_q.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                fail_cnt++;
            end else begin
                exp_r = poly_q.pop_front();
                if (got.value !== exp_r.value) begin
                    $error("value: expected %h, got %h", exp_r.value, got.value);
                    fail_cnt++;
                end
                if (got.first_der !== exp_r.first_der) begin
                    $error("first_derivative: expected %h, got %h",
                           exp_r.first_der, got.first_der);
                    fail_cnt++;
                end
                if (got.second_der !== exp_r.second_der) begin
                    $error("second_derivative: expected %h, got %h",
                           exp_r.second_der, got.second_der);
                    fail_cnt++;
                end
            end
        end
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------- input side ----------------

    task automatic send_point(input logic [31:0] pt);
        lp_result_t r;
        if (s_tvalid && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end else if (!s_tvalid && $urandom_range(99) < tx_idle_pct) begin
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pt;
        do @(posedge aclk); while (!s_tready);
        predict_poly(pt, r);
        poly_q.push_back(r);
    endtask

    // stop offering, let the core drain, then write the degree
    task automatic set_degree(input logic [5:0] d);
        s_tvalid <= 1'b0;
        while (poly_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we <= 1'b0;
        degree_reg = d;
    endtask

    function automatic logic [31:0] rand_point();
        int sel;
        sel = $urandom_range(99);
        if (sel < 75)
            return 32'($urandom_range(32'h8000_0000) - 32'h4000_0000);
        else if (sel < 87)
            case ($urandom_range(5))
                0: return 32'h4000_0000;
                1: return 32'hC000_0000;
                2: return 32'h3FFF_FFFF;
                3: return 32'hC000_0001;
                4: return 32'h0000_0000;
                default: return 32'h4000_0001;
            endcase
        else
            return $urandom;
    endfunction

    task automatic test_directed();
        logic [31:0] pts[6] = '{32'h4000_0000, 32'hC000_0000, 32'h0000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF};
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_degree(6'd0);
        foreach (pts[i]) send_point(pts[i]);
        set_degree(6'd1);
        foreach (pts[i]) send_point(pts[i]);
        set_degree(6'd2);
        send_point(32'h4000_0000);
        send_point(32'hC000_0001);
        send_point(32'h2000_0000);
        set_degree(6'd32);
        send_point(32'h4000_0000);
        send_point(32'hC000_0000);
        send_point(32'h0000_0000);
        send_point(32'hFFFF_FFFF);
        set_degree(6'd63);
        send_point(32'h1234_5678);
        send_point(32'hC000_0000);
    endtask

    task automatic test_backpressure();
        set_degree(6'd3);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        @(posedge aclk);
        hold_cycles <= 3000;
        for (int i = 0; i < 12; i++) send_point(rand_point());
    endtask

    task automatic test_random();
        int idle_tx[4] = '{0, 49, 0, 17};
        int idle_rx[4] = '{0, 0, 49, 17};
        logic [5:0] d;
        int cnt;
        for (int ph = 0; ph < 16; ph++) begin
            if (ph == 6) begin
                d = 6'd32;
                cnt = 30;
            end else if (ph == 11) begin
                d = 6'($urandom_range(33, 63));
                cnt = 15;
            end else if (ph % 5 == 4) begin
                d = 6'($urandom_range(0, 1));
                cnt = 120;
            end else if (ph % 7 == 3) begin
                d = 6'($urandom_range(9, 31));
                cnt = 40;
            end else begin
                d = 6'($urandom_range(2, 8));
                cnt = 140;
            end
            set_degree(d);
            tx_idle_pct = idle_tx[ph % 4];
            rx_stall_pct = idle_rx[ph % 4];
            for (int i = 0; i < cnt; i++) send_point(rand_point());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        degree_reg = '0;
        fail_cnt = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_cycles = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        rx_stall_pct = 0;
        while (poly_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_cnt == 0)
            $display("** legendre_poly_eval_core: PASSED **");
        else
            $display("** legendre_poly_eval_core: FAILED **");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("** legendre_poly_eval_core: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/lpe_pkg.sv
sv/legendre_poly_eval_core.sv
verif/tb_top.sv
